FILE: rtl/core/dlle_pkg.sv
// ----------------------------------------------------------------------------
// dlle_pkg: shared types and constants of the doubly linked list engine
// Node pool size, handle formats, command and status codes, and the word
// formats of both channels and of the node store port.
// ----------------------------------------------------------------------------
package dlle_pkg;

    localparam int NODES    = 256;
    localparam int HANDLE_W = $clog2(NODES + 1);
    localparam int IDX_W    = $clog2(NODES);
    localparam int VALUE_W  = 32;

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [IDX_W-1:0]    idx_t;

    // The null handle equals the pool size and marks the end position.
    localparam handle_t NULL_H = HANDLE_W'(NODES);

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_ERASE  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_BAD_POS = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        handle_t                   position;
        logic signed [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                status;
        handle_t                   result_handle;
        logic signed [VALUE_W-1:0] read_value;
        handle_t                   next_handle;
        handle_t                   prev_handle;
        handle_t                   head_handle;
        handle_t                   tail_handle;
        handle_t                   count;
    } out_word_t;

    // One cycle of requests to the node store: a read of all three
    // memories and an independent write to each of them.
    typedef struct packed {
        logic                      rd_en;
        idx_t                      rd_addr_value;
        idx_t                      rd_addr_next;
        idx_t                      rd_addr_prev;
        logic                      value_we;
        idx_t                      value_waddr;
        logic signed [VALUE_W-1:0] value_wdata;
        logic                      next_we;
        idx_t                      next_waddr;
        handle_t                   next_wdata;
        logic                      prev_we;
        idx_t                      prev_waddr;
        handle_t                   prev_wdata;
    } store_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        handle_t                   next_h;
        handle_t                   prev_h;
    } store_rsp_t;

endpackage

FILE: rtl/core/dlle_node_store.sv
// ----------------------------------------------------------------------------
// dlle_node_store: node value and link memories
// Three single-port-write, single-read memories with registered read data.
// ----------------------------------------------------------------------------
module dlle_node_store (
    input  logic                  aclk,
    input  dlle_pkg::store_req_t  req,
    output dlle_pkg::store_rsp_t  rsp
);

    logic signed [dlle_pkg::VALUE_W-1:0] value_mem [dlle_pkg::NODES];
    dlle_pkg::handle_t                   next_mem  [dlle_pkg::NODES];
    dlle_pkg::handle_t                   prev_mem  [dlle_pkg::NODES];

    logic signed [dlle_pkg::VALUE_W-1:0] rd_value_reg;
    dlle_pkg::handle_t                   rd_next_reg;
    dlle_pkg::handle_t                   rd_prev_reg;

    always_ff @(posedge aclk) begin
        if (req.value_we) begin
            value_mem[req.value_waddr] <= req.value_wdata;
        end
        if (req.rd_en) begin
            rd_value_reg <= value_mem[req.rd_addr_value];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.next_we) begin
            next_mem[req.next_waddr] <= req.next_wdata;
        end
        if (req.rd_en) begin
            rd_next_reg <= next_mem[req.rd_addr_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.prev_we) begin
            prev_mem[req.prev_waddr] <= req.prev_wdata;
        end
        if (req.rd_en) begin
            rd_prev_reg <= prev_mem[req.rd_addr_prev];
        end
    end

    assign rsp = {rd_value_reg, rd_next_reg, rd_prev_reg};

endmodule

FILE: rtl/core/doubly_linked_list_engine.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_engine: doubly linked list over a fixed node pool
// Append, insert before, erase and read commands on a list of 32-bit values.
// ----------------------------------------------------------------------------
// Usage: a command word enters on s_valid/s_ready and exactly one result
// word leaves on m_valid/m_ready. Every result carries the head, the tail
// and the node count as they stand after the command.
// A command is taken only while the engine is idle. On acceptance the links
// of the nodes it touches are read from the node store; then the first
// set of writes goes to the store, and the second write to the link memory
// is made as the result is loaded into the output register. A new command
// is not taken before the last one has left that finishing step; the read
// of the store and the two writes to the single write port of the next-link
// memory set that pace.
// Reset clears the list, the pool and the in-use map at once; node values
// and links are left as they are and their contents are never used before being written.
// While the receiver stalls a finished result waits in the output register;
// the next command is accepted, and its result waits until that register
// is drained.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dlle_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dlle_pkg::out_word_t  m_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [1:0]                          cmd_reg, cmd_next;
    dlle_pkg::handle_t                   pos_reg, pos_next;
    logic signed [dlle_pkg::VALUE_W-1:0] val_reg, val_next;

    logic [dlle_pkg::NODES-1:0] node_used_reg, node_used_next;
    dlle_pkg::handle_t head_reg, head_next;
    dlle_pkg::handle_t tail_reg, tail_next;
    dlle_pkg::handle_t fresh_count_reg, fresh_count_next;
    dlle_pkg::handle_t free_head_reg, free_head_next;
    dlle_pkg::handle_t used_count_reg, used_count_next;

    // Link writes deferred to the finishing state.
    logic              w2_next_we_reg, w2_next_we_next;
    dlle_pkg::idx_t    w2_next_addr_reg, w2_next_addr_next;
    dlle_pkg::handle_t w2_next_data_reg, w2_next_data_next;
    logic              w2_prev_we_reg, w2_prev_we_next;
    dlle_pkg::idx_t    w2_prev_addr_reg, w2_prev_addr_next;
    dlle_pkg::handle_t w2_prev_data_reg, w2_prev_data_next;

    // Per-command part of the result.
    logic [1:0]                          rs_status_reg, rs_status_next;
    dlle_pkg::handle_t                   rs_handle_reg, rs_handle_next;
    logic signed [dlle_pkg::VALUE_W-1:0] rs_value_reg, rs_value_next;
    dlle_pkg::handle_t                   rs_next_reg, rs_next_next;
    dlle_pkg::handle_t                   rs_prev_reg, rs_prev_next;

    dlle_pkg::out_word_t out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    dlle_pkg::store_req_t req;
    dlle_pkg::store_rsp_t rsp;

    logic              pos_ok;
    logic              is_append;
    logic              grab_ok;
    logic              from_free;
    dlle_pkg::handle_t new_h;
    dlle_pkg::idx_t    new_idx;
    dlle_pkg::idx_t    pos_idx;

    dlle_node_store u_store (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    assign pos_idx   = pos_reg[dlle_pkg::IDX_W-1:0];
    assign pos_ok    = (pos_reg < dlle_pkg::NULL_H) && node_used_reg[pos_idx];
    assign is_append = (cmd_reg == dlle_pkg::CMD_APPEND) || (pos_reg == dlle_pkg::NULL_H);

    // Reused nodes come off the free list first, then never-used nodes.
    always_comb begin
        from_free = free_head_reg < dlle_pkg::NULL_H;
        grab_ok   = from_free || (fresh_count_reg < dlle_pkg::NULL_H);
        new_h     = from_free ? free_head_reg : fresh_count_reg;
    end
    assign new_idx = new_h[dlle_pkg::IDX_W-1:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        pos_next          = pos_reg;
        val_next          = val_reg;
        node_used_next    = node_used_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        fresh_count_next  = fresh_count_reg;
        free_head_next    = free_head_reg;
        used_count_next   = used_count_reg;
        w2_next_we_next   = w2_next_we_reg;
        w2_next_addr_next = w2_next_addr_reg;
        w2_next_data_next = w2_next_data_reg;
        w2_prev_we_next   = w2_prev_we_reg;
        w2_prev_addr_next = w2_prev_addr_reg;
        w2_prev_data_next = w2_prev_data_reg;
        rs_status_next    = rs_status_reg;
        rs_handle_next    = rs_handle_reg;
        rs_value_next     = rs_value_reg;
        rs_next_next      = rs_next_reg;
        rs_prev_next      = rs_prev_reg;
        out_next          = out_reg;
        m_valid_next      = m_valid_reg;
        req               = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_data.command;
                    pos_next  = s_data.position;
                    val_next  = s_data.value;
                    req.rd_en = 1'b1;
                    req.rd_addr_value = s_data.position[dlle_pkg::IDX_W-1:0];
                    req.rd_addr_prev  = s_data.position[dlle_pkg::IDX_W-1:0];
                    // Appends and inserts need the free-list successor, erase and read the node's own.
                    if (s_data.command == dlle_pkg::CMD_APPEND ||
                        s_data.command == dlle_pkg::CMD_INSERT) begin
                        req.rd_addr_next = free_head_reg[dlle_pkg::IDX_W-1:0];
                    end else begin
                        req.rd_addr_next = s_data.position[dlle_pkg::IDX_W-1:0];
                    end
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                rs_status_next  = dlle_pkg::STATUS_OK;
                rs_handle_next  = dlle_pkg::NULL_H;
                rs_value_next   = '0;
                rs_next_next    = dlle_pkg::NULL_H;
                rs_prev_next    = dlle_pkg::NULL_H;
                w2_next_we_next = 1'b0;
                w2_prev_we_next = 1'b0;

                case (cmd_reg)
                    dlle_pkg::CMD_APPEND, dlle_pkg::CMD_INSERT: begin
                        if (!is_append && !pos_ok) begin
                            rs_status_next = dlle_pkg::STATUS_BAD_POS;
                        end else if (!grab_ok) begin
                            rs_status_next = dlle_pkg::STATUS_FULL;
                        end else begin
                            if (from_free) begin
                                free_head_next = rsp.next_h;
                            end else begin
                                fresh_count_next = fresh_count_reg + dlle_pkg::HANDLE_W'(1);
                            end
                            node_used_next[new_idx] = 1'b1;
                            used_count_next = used_count_reg + dlle_pkg::HANDLE_W'(1);
                            rs_handle_next  = new_h;
                            req.value_we    = 1'b1;
                            req.value_waddr = new_idx;
                            req.value_wdata = val_reg;
                            req.next_we     = 1'b1;
                            req.next_waddr  = new_idx;
                            req.prev_we     = 1'b1;
                            req.prev_waddr  = new_idx;
                            if (is_append) begin
                                req.next_wdata = dlle_pkg::NULL_H;
                                req.prev_wdata = tail_reg;
                                if (tail_reg < dlle_pkg::NULL_H) begin
                                    w2_next_we_next   = 1'b1;
                                    w2_next_addr_next = tail_reg[dlle_pkg::IDX_W-1:0];
                                    w2_next_data_next = new_h;
                                end else begin
                                    head_next = new_h;
                                end
                                tail_next = new_h;
                            end else begin
                                req.next_wdata    = pos_reg;
                                req.prev_wdata    = rsp.prev_h;
                                w2_prev_we_next   = 1'b1;
                                w2_prev_addr_next = pos_idx;
                                w2_prev_data_next = new_h;
                                if (rsp.prev_h < dlle_pkg::NULL_H) begin
                                    w2_next_we_next   = 1'b1;
                                    w2_next_addr_next = rsp.prev_h[dlle_pkg::IDX_W-1:0];
                                    w2_next_data_next = new_h;
                                end else begin
                                    head_next = new_h;
                                end
                            end
                        end
                    end

                    dlle_pkg::CMD_ERASE: begin
                        if (!pos_ok) begin
                            rs_status_next = dlle_pkg::STATUS_BAD_POS;
                        end else begin
                            if (pos_reg == head_reg || rsp.prev_h >= dlle_pkg::NULL_H) begin
                                head_next = rsp.next_h;
                            end else begin
                                w2_next_we_next   = 1'b1;
                                w2_next_addr_next = rsp.prev_h[dlle_pkg::IDX_W-1:0];
                                w2_next_data_next = rsp.next_h;
                            end
                            if (pos_reg == tail_reg || rsp.next_h >= dlle_pkg::NULL_H) begin
                                tail_next = rsp.prev_h;
                            end else begin
                                req.prev_we    = 1'b1;
                                req.prev_waddr = rsp.next_h[dlle_pkg::IDX_W-1:0];
                                req.prev_wdata = rsp.prev_h;
                            end
                            // The freed node is pushed on the free list through its next link.
                            req.next_we     = 1'b1;
                            req.next_waddr  = pos_idx;
                            req.next_wdata  = free_head_reg;
                            free_head_next  = pos_reg;
                            node_used_next[pos_idx] = 1'b0;
                            used_count_next = used_count_reg - dlle_pkg::HANDLE_W'(1);
                            rs_handle_next  = rsp.next_h;
                        end
                    end

                    default: begin
                        if (!pos_ok) begin
                            rs_status_next = dlle_pkg::STATUS_BAD_POS;
                        end else begin
                            rs_handle_next = pos_reg;
                            rs_value_next  = rsp.value;
                            rs_next_next   = rsp.next_h;
                            rs_prev_next   = rsp.prev_h;
                        end
                    end
                endcase
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                // Repeating these writes while the output stalls is harmless.
                req.next_we    = w2_next_we_reg;
                req.next_waddr = w2_next_addr_reg;
                req.next_wdata = w2_next_data_reg;
                req.prev_we    = w2_prev_we_reg;
                req.prev_waddr = w2_prev_addr_reg;
                req.prev_wdata = w2_prev_data_reg;
                if (!m_valid_reg || m_ready) begin
                    out_next.status        = rs_status_reg;
                    out_next.result_handle = rs_handle_reg;
                    out_next.read_value    = rs_value_reg;
                    out_next.next_handle   = rs_next_reg;
                    out_next.prev_handle   = rs_prev_reg;
                    out_next.head_handle   = head_reg;
                    out_next.tail_handle   = tail_reg;
                    out_next.count         = used_count_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            node_used_reg   <= '0;
            head_reg        <= dlle_pkg::NULL_H;
            tail_reg        <= dlle_pkg::NULL_H;
            fresh_count_reg <= '0;
            free_head_reg   <= dlle_pkg::NULL_H;
            used_count_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            node_used_reg   <= node_used_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            fresh_count_reg <= fresh_count_next;
            free_head_reg   <= free_head_next;
            used_count_reg  <= used_count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg          <= cmd_next;
        pos_reg          <= pos_next;
        val_reg          <= val_next;
        w2_next_we_reg   <= w2_next_we_next;
        w2_next_addr_reg <= w2_next_addr_next;
        w2_next_data_reg <= w2_next_data_next;
        w2_prev_we_reg   <= w2_prev_we_next;
        w2_prev_addr_reg <= w2_prev_addr_next;
        w2_prev_data_reg <= w2_prev_data_next;
        rs_status_reg    <= rs_status_next;
        rs_handle_reg    <= rs_handle_next;
        rs_value_reg     <= rs_value_next;
        rs_next_reg      <= rs_next_next;
        rs_prev_reg      <= rs_prev_next;
        out_reg          <= out_next;
    end

endmodule
